// ===== src/lpm_pkg.sv =====
// Shared constants and helpers for the lowercase pattern masker.
`default_nettype none
package lpm_pkg;

  localparam int CHAR_W = 8;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W = 5;
  // Pattern register space: two 64-bit words hold up to sixteen bytes.
  localparam int PAT_BYTES = 16;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef logic [CHAR_W-1:0] char_t;

  function automatic char_t fold_case(input char_t c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c | CASE_BIT;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/lowercase_pattern_masker.sv =====
// Lowercase pattern masker: case fold, window compare, star masking, output skid.
// Ordering: the request that completes a pattern-length window pops its oldest byte at its
//   own accepting edge into the output register, or into the skid entry on a stall.
// Throughput: one byte per cycle in steady state; a final byte, or a shorter pattern length
//   set mid-text, holds input while the extra bytes (up to 15) drain; a stalled output
//   parks one byte in the skid entry and holds input until it moves up.
// Reset (rst_n low, synchronous): window empty, pattern registers zero (pass through).
`default_nettype none
module lowercase_pattern_masker #(
  parameter int PATTERN_MAX = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // config write port
  input  wire                             cfg_wr_en,
  input  wire [lpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lpm_pkg::CFG_W-1:0]        cfg_wdata,
  // input stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [7:0]                       in_tdata,   // [7:0] text_char
  input  wire                             in_tlast,   // text_last
  // output stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_char
  output logic                            out_tlast   // out_last
);
  import lpm_pkg::*;

  localparam int WIN_DEPTH = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int WIN_BITS = WIN_DEPTH * CHAR_W;
  localparam int FILL_W = $clog2(WIN_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(WIN_DEPTH);

  // configuration
  logic [CFG_W-1:0]       pat_low_r;
  logic [CFG_W-1:0]       pat_high_r;
  logic [LEN_W-1:0]       pat_len_r;
  logic [2*CFG_W-1:0]     pat_vec;
  logic [LEN_W-1:0]       len_eff;

  // window
  logic [WIN_BITS-1:0]    win_r;
  logic [WIN_BITS-1:0]    win_nxt;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;
  logic                   pend_r;
  logic                   pend_nxt;
  logic                   flush_r;
  logic                   flush_nxt;

  // datapath
  logic                   push;
  logic                   active;
  logic                   last_flag;
  logic                   pop;
  logic                   pop_last;
  logic                   hit;
  logic [FILL_W-1:0]      vfill;
  logic [WIN_BITS-1:0]    view_vec;
  logic [WIN_BITS-1:0]    star_vec;
  logic [WIN_BITS-1:0]    shift_vec;
  char_t                  in_char;

  // output register plus skid
  logic                   out_v_r;
  logic                   skid_v_r;
  char_t                  out_char_r;
  logic                   out_last_r;
  char_t                  skid_char_r;
  logic                   skid_last_r;
  logic                   out_fire;

  function automatic logic needs_pop(input logic [FILL_W-1:0] f,
                                     input logic [LEN_W-1:0] len,
                                     input logic lf);
    logic cmp_ok;
    cmp_ok = (len != '0) && (LEN_W'(f) >= len);
    return cmp_ok || (((len == '0) || lf) && (f != '0));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r <= '0;
      pat_high_r <= '0;
      pat_len_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LOW: pat_low_r <= cfg_wdata;
        REG_PATTERN_HIGH: pat_high_r <= cfg_wdata;
        REG_PATTERN_LENGTH: pat_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_vec = {pat_high_r, pat_low_r};
  assign len_eff = (pat_len_r > LEN_CAP) ? LEN_CAP : pat_len_r;

  assign in_tready = !pend_r && !skid_v_r;
  assign push = in_tvalid && in_tready;
  assign active = push || pend_r;
  assign last_flag = flush_r || (push && in_tlast);
  assign in_char = fold_case(in_tdata);
  assign vfill = fill_r + FILL_W'(push);

  always_comb begin
    // window as seen with the incoming byte placed after the held ones
    for (int i = 0; i < WIN_DEPTH; i++) begin
      view_vec[i*CHAR_W +: CHAR_W] = (push && fill_r == FILL_W'(i)) ? in_char
                                                                    : win_r[i*CHAR_W +: CHAR_W];
    end
    hit = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (LEN_W'(k) < len_eff && view_vec[k*CHAR_W +: CHAR_W] != pat_vec[k*CHAR_W +: CHAR_W]) begin
        hit = 1'b0;
      end
    end
    // compare only counts when the window is full enough for the pattern
    if (len_eff == '0 || LEN_W'(vfill) < len_eff) begin
      hit = 1'b0;
    end
    for (int k = 0; k < WIN_DEPTH; k++) begin
      star_vec[k*CHAR_W +: CHAR_W] = (hit && LEN_W'(k) < len_eff) ? STAR_CHAR
                                                                   : view_vec[k*CHAR_W +: CHAR_W];
    end
    shift_vec = star_vec >> CHAR_W;

    pop = active && !skid_v_r && needs_pop(vfill, len_eff, last_flag);
    pop_last = last_flag && (vfill == FILL_W'(1));
    win_nxt = pop ? shift_vec : view_vec;
    fill_nxt = vfill - FILL_W'(pop);
    pend_nxt = active && needs_pop(fill_nxt, len_eff, last_flag);
    flush_nxt = pend_nxt && last_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign out_fire = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (pop) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_char_r <= skid_char_r;
        out_last_r <= skid_last_r;
      end
    end else if (pop) begin
      if (out_v_r && !out_tready) begin
        skid_char_r <= star_vec[CHAR_W-1:0];
        skid_last_r <= pop_last;
      end else begin
        out_char_r <= star_vec[CHAR_W-1:0];
        out_last_r <= pop_last;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_char_r;
  assign out_tlast = out_last_r;

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a head entry");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r < FILL_W'(WIN_DEPTH))
    else $error("byte pushed into a full window");

  a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> pend_r)
    else $error("flush marked with no pending drain");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_last) |=> (fill_r == '0) && !pend_r && !flush_r)
    else $error("window not empty after final byte");

endmodule
`default_nettype wire
